/* rtl/core/bit_manipulation_alu_defines.svh */
// Assertion helpers used by the RTL.
`ifndef BIT_MANIPULATION_ALU_DEFINES_SVH
`define BIT_MANIPULATION_ALU_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit unit check failed");

// Next-cycle implication, checked out of reset.
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit unit check failed");

`endif

/* rtl/core/bma_pkg.sv */
package bma_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = $clog2(WORD_W);
    localparam int OP_W   = 4;
    localparam int SMALL_W = 8;
    localparam int STAT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_AND     = 4'd0,
        OP_OR      = 4'd1,
        OP_XOR     = 4'd2,
        OP_NOT     = 4'd3,
        OP_SHIFT   = 4'd4,
        OP_ROTATE  = 4'd5,
        OP_FIELD   = 4'd6,
        OP_BIT_GET = 4'd7,
        OP_BIT_SET = 4'd8,
        OP_HIGH    = 4'd9,
        OP_LOW     = 4'd10
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_BOUNDS   = 3'd2,
        ST_SIZE     = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [WORD_W-1:0]  operand_a;
        logic signed [WORD_W-1:0]  operand_b;
        logic signed [SMALL_W-1:0] count;
        logic signed [SMALL_W-1:0] bit_index;
        logic                      new_bit;
    } t_item;

endpackage

/* rtl/core/bit_manipulation_alu.sv */
// Bit-manipulation unit on a 32-bit signed word: and, or, xor, not, arithmetic
// shift with exact overflow detection, rotate, field extract, single-bit get
// and set, and highest/lowest set-bit index. Each beat carries one operation and
// yields one result word plus a status; whenever status is not ok the word is
// zero. A beat passes through an input register, then single-pass combinational
// logic into the result register, and a new beat is taken every cycle while the
// output side keeps taking results.
`include "bit_manipulation_alu_defines.svh"

module bit_manipulation_alu (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [bma_pkg::OP_W-1:0]               i_operation,
    input  logic signed [bma_pkg::WORD_W-1:0]      i_operand_a,
    input  logic signed [bma_pkg::WORD_W-1:0]      i_operand_b,
    input  logic signed [bma_pkg::SMALL_W-1:0]     i_count,
    input  logic signed [bma_pkg::SMALL_W-1:0]     i_bit_index,
    input  logic                                   i_new_bit,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [bma_pkg::WORD_W-1:0]      o_result,
    output logic [bma_pkg::STAT_W-1:0]             o_status
);
    import bma_pkg::*;

    logic                     r_s1_valid;
    logic                     n_s1_valid;
    t_item                    r_s1_item;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [WORD_W-1:0] r_result;
    t_status                  r_status;
    logic signed [WORD_W-1:0] exec_result;
    t_status                  exec_status;
    logic                     advance;
    logic                     take_in;

    // the output register frees up when empty or when its beat is taken
    assign advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;
    assign take_in = i_valid && o_ready;

    assign n_s1_valid  = take_in || (r_s1_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_item.operation <= i_operation;
            r_s1_item.operand_a <= i_operand_a;
            r_s1_item.operand_b <= i_operand_b;
            r_s1_item.count     <= i_count;
            r_s1_item.bit_index <= i_bit_index;
            r_s1_item.new_bit   <= i_new_bit;
        end
    end

    bma_exec u_exec (
        .i_item   (r_s1_item),
        .o_result (exec_result),
        .o_status (exec_status)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= exec_result;
            r_status <= exec_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign o_status = r_status;

    `BMA_ASSERT_NEXT(a_take_fills_stage, i_clk, i_rst_n, take_in, r_s1_valid)
    `BMA_ASSERT_NEXT(a_stall_holds_stage, i_clk, i_rst_n, r_s1_valid && !advance,
                     r_s1_valid && $stable(r_s1_item))
    `BMA_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)
    `BMA_ASSERT_SAME(a_error_zero_word, i_clk, i_rst_n,
                     r_out_valid && (r_status != ST_OK), r_result == '0)

endmodule

/* rtl/core/bma_exec.sv */
module bma_exec (
    input  bma_pkg::t_item                    i_item,
    output logic signed [bma_pkg::WORD_W-1:0] o_result,
    output bma_pkg::t_status                  o_status
);
    import bma_pkg::*;

    logic signed [WORD_W-1:0]  a;
    logic signed [SMALL_W-1:0] c;
    logic signed [SMALL_W-1:0] bi;
    logic signed [SMALL_W:0]   neg_c;
    logic signed [SMALL_W:0]   field_lo;
    logic [WORD_W-1:0]         shl;
    logic signed [WORD_W-1:0]  shl_back;
    logic                      shl_ovf;
    logic [WORD_W-1:0]         shr;
    logic [WORD_W-1:0]         rot;
    logic [WORD_W-1:0]         field_mask;
    logic [WORD_W-1:0]         field_val;
    logic                      idx_bad;
    logic [IDX_W-1:0]          hi_idx;
    logic [IDX_W-1:0]          lo_idx;
    logic [WORD_W-1:0]         res;
    t_status                   st;

    assign a  = i_item.operand_a;
    assign c  = i_item.count;
    assign bi = i_item.bit_index;

    assign neg_c    = -{c[SMALL_W-1], c};
    assign field_lo = {bi[SMALL_W-1], bi} - {c[SMALL_W-1], c} + (SMALL_W+1)'(1);

    // left shift fits when shifting back arithmetically restores the word
    assign shl      = a << c[IDX_W-1:0];
    assign shl_back = $signed(shl) >>> c[IDX_W-1:0];
    assign shl_ovf  = (c >= SMALL_W'(WORD_W)) || (shl_back != a);
    assign shr      = (neg_c >= (SMALL_W+1)'(WORD_W)) ? {WORD_W{a[WORD_W-1]}}
                                                      : WORD_W'(a >>> neg_c[IDX_W-1:0]);

    assign rot = (a << c[IDX_W-1:0]) | (a >> (IDX_W+1)'(WORD_W - c[IDX_W-1:0]));

    // a width of exactly WORD_W shifts every one out, leaving a full mask
    assign field_mask = ~({WORD_W{1'b1}} << c[IDX_W:0]);
    assign field_val  = (a >> field_lo[IDX_W-1:0]) & field_mask;

    assign idx_bad = (bi < 0) || (bi >= SMALL_W'(WORD_W));

    always_comb begin
        hi_idx = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (a[k]) begin
                hi_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        lo_idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (a[k]) begin
                lo_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        res = '0;
        st  = ST_OK;
        unique case (i_item.operation)
            OP_AND:  res = a & i_item.operand_b;
            OP_OR:   res = a | i_item.operand_b;
            OP_XOR:  res = a ^ i_item.operand_b;
            OP_NOT:  res = ~a;
            OP_SHIFT: begin
                if (a == '0 || c == '0) begin
                    res = a;
                end else if (c > 0) begin
                    if (shl_ovf) begin
                        st = ST_OVERFLOW;
                    end else begin
                        res = shl;
                    end
                end else begin
                    res = shr;
                end
            end
            OP_ROTATE: res = rot;
            OP_FIELD: begin
                if (c <= 0) begin
                    st = ST_SIZE;
                end else if (bi >= SMALL_W'(WORD_W) || field_lo < 0) begin
                    st = ST_BOUNDS;
                end else begin
                    res = field_val;
                end
            end
            OP_BIT_GET: begin
                if (idx_bad) begin
                    st = ST_BOUNDS;
                end else begin
                    res = WORD_W'(a[bi[IDX_W-1:0]]);
                end
            end
            OP_BIT_SET: begin
                if (idx_bad) begin
                    st = ST_BOUNDS;
                end else begin
                    res = a;
                    res[bi[IDX_W-1:0]] = i_item.new_bit;
                end
            end
            OP_HIGH: begin
                if (a == '0) begin
                    st = ST_NONE;
                end else begin
                    res = WORD_W'(hi_idx);
                end
            end
            OP_LOW: begin
                if (a == '0) begin
                    st = ST_NONE;
                end else begin
                    res = WORD_W'(lo_idx);
                end
            end
            default: st = ST_BOUNDS;
        endcase
        // any error forces a zero word
        if (st != ST_OK) begin
            res = '0;
        end
    end

    assign o_result = res;
    assign o_status = st;

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bma_pkg::*;

    localparam logic [OP_W-1:0]          OP_UNDEFINED = 4'd15;
    localparam logic signed [WORD_W-1:0] MIN_WORD     = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] MAX_WORD     = 32'sh7fff_ffff;
    localparam int                       RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic [STAT_W-1:0]        status;
    } t_outcome;

    typedef struct {
        t_item    item;
        bit       typed;
        t_outcome want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation = '0;
    logic signed [WORD_W-1:0]  i_operand_a = '0;
    logic signed [WORD_W-1:0]  i_operand_b = '0;
    logic signed [SMALL_W-1:0] i_count = '0;
    logic signed [SMALL_W-1:0] i_bit_index = '0;
    logic                      i_new_bit = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [WORD_W-1:0]  o_result;
    logic [STAT_W-1:0]         o_status;

    t_outcome pending_results[$];
    int       mismatches = 0;

    bit_manipulation_alu uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_count     (i_count),
        .i_bit_index (i_bit_index),
        .i_new_bit   (i_new_bit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .o_status    (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_outcome compute_bit_op(t_item it);
        t_outcome                 o;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] top;
        logic [WORD_W-1:0]        mask;
        logic [2*WORD_W-1:0]      dbl;
        int                       c;
        int                       bi;
        int                       k;
        a = it.operand_a;
        c = $signed(it.count);
        bi = $signed(it.bit_index);
        o.result = '0;
        o.status = ST_OK;
        case (it.operation)
            OP_AND: o.result = a & it.operand_b;
            OP_OR:  o.result = a | it.operand_b;
            OP_XOR: o.result = a ^ it.operand_b;
            OP_NOT: o.result = ~a;
            OP_SHIFT: begin
                if (a == 0 || c == 0) begin
                    o.result = a;
                end else if (c > 0) begin
                    // the top c+1 bits must all match the sign
                    if (c >= WORD_W) begin
                        o.status = ST_OVERFLOW;
                    end else begin
                        top = a >>> (WORD_W - 1 - c);
                        if (top != '0 && top != '1)
                            o.status = ST_OVERFLOW;
                        else
                            o.result = a << c;
                    end
                end else if (-c >= WORD_W) begin
                    o.result = a[WORD_W-1] ? '1 : '0;
                end else begin
                    o.result = a >>> (-c);
                end
            end
            OP_ROTATE: begin
                dbl = {a, a} << (c & (WORD_W - 1));
                o.result = dbl[2*WORD_W-1:WORD_W];
            end
            OP_FIELD: begin
                if (c <= 0) begin
                    o.status = ST_SIZE;
                end else if (bi >= WORD_W || bi - (c - 1) < 0) begin
                    o.status = ST_BOUNDS;
                end else begin
                    mask = ~({WORD_W{1'b1}} << c);
                    o.result = ($unsigned(a) >> (bi - c + 1)) & mask;
                end
            end
            OP_BIT_GET, OP_BIT_SET: begin
                if (bi < 0 || bi >= WORD_W) begin
                    o.status = ST_BOUNDS;
                end else if (it.operation == OP_BIT_GET) begin
                    o.result = {{(WORD_W-1){1'b0}}, a[bi[IDX_W-1:0]]};
                end else begin
                    o.result = a;
                    o.result[bi[IDX_W-1:0]] = it.new_bit;
                end
            end
            OP_HIGH: begin
                if (a == 0) begin
                    o.status = ST_NONE;
                end else if (a[WORD_W-1]) begin
                    o.result = WORD_W - 1;
                end else begin
                    // ascending scan leaves the top set bit
                    for (k = 0; k < WORD_W; k++)
                        if (a[k]) o.result = k;
                end
            end
            OP_LOW: begin
                if (a == 0) begin
                    o.status = ST_NONE;
                end else begin
                    for (k = WORD_W - 1; k >= 0; k--)
                        if (a[k]) o.result = k;
                end
            end
            default: o.status = ST_BOUNDS;
        endcase
        if (o.status != ST_OK)
            o.result = '0;
        return o;
    endfunction

    function automatic t_row directed_row(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] a,
                                          logic signed [WORD_W-1:0] b, int c, int bi, bit nb,
                                          bit typed, logic signed [WORD_W-1:0] res,
                                          t_status st);
        t_row r;
        r.item.operation = op;
        r.item.operand_a = a;
        r.item.operand_b = b;
        r.item.count = c[SMALL_W-1:0];
        r.item.bit_index = bi[SMALL_W-1:0];
        r.item.new_bit = nb;
        r.typed = typed;
        r.want.result = res;
        r.want.status = st;
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] random_word();
        logic signed [WORD_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = $urandom;
            1: w = $signed($urandom) >>> $urandom_range(0, 31);
            2: w = WORD_W'($urandom_range(0, 8)) - 4;
            3: begin
                case ($urandom_range(0, 3))
                    0: w = MIN_WORD;
                    1: w = MAX_WORD;
                    2: w = '0;
                    default: w = '1;
                endcase
            end
            4: w = 32'sd1 <<< $urandom_range(0, 31);
            default: w = ~(32'sd1 <<< $urandom_range(0, 31));
        endcase
        return w;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    c;
        bit    shaped;
        if ($urandom_range(0, 19) == 0)
            it.operation = OP_W'($urandom_range(11, 15));
        else
            it.operation = OP_W'($urandom_range(0, 10));
        it.operand_a = random_word();
        it.operand_b = random_word();
        it.count = SMALL_W'($urandom);
        it.bit_index = SMALL_W'($urandom);
        it.new_bit = 1'($urandom_range(0, 1));
        shaped = ($urandom_range(0, 3) != 0);
        // keep most amounts and fields near the interesting boundaries
        if (shaped) begin
            case (it.operation)
                OP_SHIFT, OP_ROTATE: it.count = SMALL_W'($urandom_range(0, 70) - 35);
                OP_FIELD: begin
                    c = $urandom_range(1, 32);
                    it.count = SMALL_W'(c);
                    it.bit_index = SMALL_W'($urandom_range(c - 1, 31));
                end
                OP_BIT_GET, OP_BIT_SET: it.bit_index = SMALL_W'($urandom_range(0, 31));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic offer_item(t_item it, bit typed, t_outcome want);
        i_valid <= 1'b1;
        i_operation <= it.operation;
        i_operand_a <= it.operand_a;
        i_operand_b <= it.operand_b;
        i_count <= it.count;
        i_bit_index <= it.bit_index;
        i_new_bit <= it.new_bit;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(typed ? want : compute_bit_op(it));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // receiver: switches between random stall patterns, with a long hold now and then
    initial begin : result_sink
        int             cyc;
        int             hold;
        int             mode;
        logic [7:0]     pat;
        cyc = 0;
        hold = 0;
        mode = 0;
        pat = 8'hff;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 128 == 0) begin
                mode = $urandom_range(0, 3);
                pat = 8'($urandom);
            end
            if (cyc % 2500 == 700)
                hold = 150;
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 7) != 0);
                    default: i_ready <= pat[cyc[2:0]];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: result %h status %0d", o_result, o_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, o_result);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row     rows[$];
        t_outcome blank;
        int       n;
        int       burst_left;
        int       gap;
        blank = '0;

        rows.push_back(directed_row(OP_AND, '1, MIN_WORD, 0, 0, 0, 1, MIN_WORD, ST_OK));
        rows.push_back(directed_row(OP_XOR, 32'sh5555_5555, '1, 0, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_NOT, MAX_WORD, 0, 0, 0, 0, 1, MIN_WORD, ST_OK));
        rows.push_back(directed_row(OP_SHIFT, 1, 0, 127, 0, 0, 1, 0, ST_OVERFLOW));
        rows.push_back(directed_row(OP_SHIFT, 0, 0, 127, 0, 0, 1, 0, ST_OK));
        rows.push_back(directed_row(OP_SHIFT, 32'sh3fff_ffff, 0, 1, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_SHIFT, 32'sh4000_0000, 0, 1, 0, 0, 1, 0, ST_OVERFLOW));
        rows.push_back(directed_row(OP_SHIFT, '1, 0, 31, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_SHIFT, MIN_WORD, 0, -128, 0, 0, 1, '1, ST_OK));
        rows.push_back(directed_row(OP_SHIFT, MAX_WORD, 0, -32, 0, 0, 1, 0, ST_OK));
        rows.push_back(directed_row(OP_ROTATE, 32'sh8000_0001, 0, -1, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_ROTATE, 32'sh1234_5678, 0, -128, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_FIELD, '1, 0, 0, 5, 0, 1, 0, ST_SIZE));
        rows.push_back(directed_row(OP_FIELD, '1, 0, -128, 5, 0, 1, 0, ST_SIZE));
        rows.push_back(directed_row(OP_FIELD, '1, 0, 1, 32, 0, 1, 0, ST_BOUNDS));
        rows.push_back(directed_row(OP_FIELD, '1, 0, 5, 3, 0, 1, 0, ST_BOUNDS));
        rows.push_back(directed_row(OP_FIELD, '1, 0, 32, 31, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_BIT_GET, '1, 0, 0, -1, 0, 1, 0, ST_BOUNDS));
        rows.push_back(directed_row(OP_BIT_GET, MIN_WORD, 0, 0, 31, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_BIT_SET, 0, 0, 0, 31, 1, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_BIT_SET, '1, 0, 0, 127, 1, 1, 0, ST_BOUNDS));
        rows.push_back(directed_row(OP_HIGH, 0, 0, 0, 0, 0, 1, 0, ST_NONE));
        rows.push_back(directed_row(OP_HIGH, '1, 0, 0, 0, 0, 1, 31, ST_OK));
        rows.push_back(directed_row(OP_HIGH, 1, 0, 0, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_LOW, MIN_WORD, 0, 0, 0, 0, 0, 0, ST_OK));
        rows.push_back(directed_row(OP_LOW, 0, 0, 0, 0, 0, 1, 0, ST_NONE));
        rows.push_back(directed_row(OP_UNDEFINED, '1, '1, 0, 0, 0, 1, 0, ST_BOUNDS));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            offer_item(rows[k].item, rows[k].typed, rows[k].want);
        drain_results();

        burst_left = $urandom_range(1, 12);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            offer_item(random_item(), 1'b0, blank);
            burst_left--;
            if (burst_left == 0) begin
                gap = $urandom_range(0, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
